FILE: rtl/core/mssd_pkg.sv
// ----------------------------------------------------------------------------
// mssd_pkg
// Shared types, command and register codes, and decimal and segment tables
// for the multiplexed seven-segment number driver.
// ----------------------------------------------------------------------------
package mssd_pkg;

  // command codes of an input beat
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_COMMON_ANODE    = 2'd0;
  localparam logic [1:0] REG_FIRST_DIGIT_PIN = 2'd1;
  localparam logic [1:0] REG_SCAN_UPWARD     = 2'd2;

  // symbol code for the minus sign
  localparam logic [3:0] DASH_CODE = 4'd10;

  // clamp limits of the shown number
  localparam logic signed [14:0] NUM_MIN = -15'sd999;
  localparam logic signed [14:0] NUM_MAX = 15'sd9999;

  // reciprocal constants: x * K >> S equals x / N over the used range
  localparam logic [13:0] RECIP_1000 = 14'd8389;  // shift 23, x < 10000
  localparam logic [5:0]  RECIP_100  = 6'd41;     // shift 12, x < 1000

  // configuration register set
  typedef struct packed {
    logic       common_anode;
    logic [2:0] first_digit_pin;
    logic       scan_upward;
  } cfg_t;

  // beat after clamp and thousands split
  typedef struct packed {
    logic        cmd;
    logic        neg;
    logic [3:0]  thou;
    logic [9:0]  rem;
    logic [15:0] passes;
  } dec_t;

  // digit times 1000
  function automatic logic [13:0] times_1000(logic [3:0] d);
    logic [13:0] r;
    case (d)
      4'd1:    r = 14'd1000;
      4'd2:    r = 14'd2000;
      4'd3:    r = 14'd3000;
      4'd4:    r = 14'd4000;
      4'd5:    r = 14'd5000;
      4'd6:    r = 14'd6000;
      4'd7:    r = 14'd7000;
      4'd8:    r = 14'd8000;
      4'd9:    r = 14'd9000;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

  // digit times 100
  function automatic logic [9:0] times_100(logic [3:0] d);
    logic [9:0] r;
    case (d)
      4'd1:    r = 10'd100;
      4'd2:    r = 10'd200;
      4'd3:    r = 10'd300;
      4'd4:    r = 10'd400;
      4'd5:    r = 10'd500;
      4'd6:    r = 10'd600;
      4'd7:    r = 10'd700;
      4'd8:    r = 10'd800;
      4'd9:    r = 10'd900;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // digit times 10
  function automatic logic [6:0] times_10(logic [3:0] d);
    logic [6:0] r;
    case (d)
      4'd1:    r = 7'd10;
      4'd2:    r = 7'd20;
      4'd3:    r = 7'd30;
      4'd4:    r = 7'd40;
      4'd5:    r = 7'd50;
      4'd6:    r = 7'd60;
      4'd7:    r = 7'd70;
      4'd8:    r = 7'd80;
      4'd9:    r = 7'd90;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // tens digit of a value below 100, by parallel threshold compares
  function automatic logic [3:0] tens_digit(logic [6:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(10 * k)) n = n + 4'd1;
    end
    return n;
  endfunction

  // segment byte for a symbol in the chosen polarity
  function automatic logic [7:0] seg_code(logic [3:0] code, logic anode);
    logic [7:0] c;
    case (code)
      4'd0:    c = 8'h3F;
      4'd1:    c = 8'h06;
      4'd2:    c = 8'h5B;
      4'd3:    c = 8'h4F;
      4'd4:    c = 8'h66;
      4'd5:    c = 8'h6D;
      4'd6:    c = 8'h7D;
      4'd7:    c = 8'h07;
      4'd8:    c = 8'h7F;
      4'd9:    c = 8'h6F;
      4'd10:   c = 8'h40;
      default: c = 8'h00;
    endcase
    return anode ? ~c : c;
  endfunction

endpackage

FILE: rtl/core/multiplexed_seven_segment_number_driver_top.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_number_driver_top
// Four-digit multiplexed seven-segment number driver with configuration
// registers.
// ----------------------------------------------------------------------------
// A load beat (cmd 0) takes a signed number, clamps it to -999..9999, splits
// it into four decimal positions with a leading minus for negatives and
// blanked leading zeros, and arms a count of four-digit refresh passes; it
// gives no result. A tick beat (cmd 1) gives one result: the segment byte
// and active-low select byte for the current position, then steps the
// position while passes remain. The block takes one beat per clock while
// the result side does not stall it; a tick passes through the input
// register, the split register and the result register, and the last
// stage also finishes the hundreds and tens split. The result register frees
// the input side whenever the result is taken or empty. Configuration
// writes are registered and apply to the next tick reaching the last stage.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_number_driver_top (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [2:0]           cfg_wdata,
  // input beats
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic signed [14:0]   in_number,
  input  logic [15:0]          in_passes,
  // result beats
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_segments,
  output logic [7:0]           out_digit_select,
  output logic [1:0]           out_position
);
  import mssd_pkg::*;

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  advance;
  logic  dec_valid;
  dec_t  dec;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_COMMON_ANODE:    cfg_nxt.common_anode    = cfg_wdata[0];
        REG_FIRST_DIGIT_PIN: cfg_nxt.first_digit_pin = cfg_wdata;
        REG_SCAN_UPWARD:     cfg_nxt.scan_upward     = cfg_wdata[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.common_anode    <= 1'b0;
      cfg_r.first_digit_pin <= 3'd7;
      cfg_r.scan_upward     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_ready = advance;

  // clamp and thousands split
  mssd_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_number (in_number),
    .in_passes (in_passes),
    .dec_valid (dec_valid),
    .dec       (dec)
  );

  // digit store, scan and result register
  mssd_scan u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .dec_valid        (dec_valid),
    .dec              (dec),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segments     (out_segments),
    .out_digit_select (out_digit_select),
    .out_position     (out_position)
  );

endmodule

FILE: rtl/core/mssd_split.sv
// ----------------------------------------------------------------------------
// mssd_split
// Input register and thousands split: clamps the number, takes its
// magnitude, then splits off the thousands digit and the remainder.
// ----------------------------------------------------------------------------
module mssd_split (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  input  logic signed [14:0]   in_number,
  input  logic [15:0]          in_passes,
  output logic                 dec_valid,
  output mssd_pkg::dec_t       dec
);
  import mssd_pkg::*;

  logic signed [14:0] clamped;
  logic [13:0]        mag;

  logic               s1_valid_r;
  logic               s1_cmd_r;
  logic               s1_neg_r;
  logic [13:0]        s1_mag_r;
  logic [15:0]        s1_passes_r;

  logic [27:0]        thou_prod;
  logic [3:0]         thou;
  logic [13:0]        rem_full;
  dec_t               dec_nxt;

  logic               s2_valid_r;
  dec_t               dec_r;

  // clamp and magnitude
  always_comb begin
    if (in_number < NUM_MIN) begin
      clamped = NUM_MIN;
    end else if (in_number > NUM_MAX) begin
      clamped = NUM_MAX;
    end else begin
      clamped = in_number;
    end
    mag = clamped[14] ? 14'(-clamped) : clamped[13:0];
  end

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd_r    <= in_cmd;
      s1_neg_r    <= clamped[14];
      s1_mag_r    <= mag;
      s1_passes_r <= in_passes;
    end
  end

  // thousands digit by reciprocal multiply, remainder by table subtract
  always_comb begin
    thou_prod      = 28'(s1_mag_r) * 28'(RECIP_1000);
    thou           = thou_prod[26:23];
    rem_full       = s1_mag_r - times_1000(thou);
    dec_nxt.cmd    = s1_cmd_r;
    dec_nxt.neg    = s1_neg_r;
    dec_nxt.thou   = thou;
    dec_nxt.rem    = rem_full[9:0];
    dec_nxt.passes = s1_passes_r;
  end

  // split register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // split register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec_valid = s2_valid_r;
  assign dec       = dec_r;

endmodule

FILE: rtl/core/mssd_scan.sv
// ----------------------------------------------------------------------------
// mssd_scan
// Digit store, scan position and pass counter, and the result register.
// A load finishes the decimal split and fills the store; a tick gives one
// result and, while passes remain, drives one position and steps the scan.
// ----------------------------------------------------------------------------
module mssd_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mssd_pkg::cfg_t       cfg,
  input  logic                 dec_valid,
  input  mssd_pkg::dec_t       dec,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_segments,
  output logic [7:0]           out_digit_select,
  output logic [1:0]           out_position
);
  import mssd_pkg::*;

  logic        fire;
  logic        is_tick;

  // load path
  logic [15:0] hund_prod;
  logic [3:0]  hund;
  logic [9:0]  rem100_full;
  logic [6:0]  rem100;
  logic [3:0]  tens;
  logic [6:0]  units_full;
  logic [3:0]  load_codes [4];
  logic [3:0]  load_shown;

  // scan state
  logic [3:0]  codes_r [4];
  logic [3:0]  codes_nxt [4];
  logic [3:0]  shown_r;
  logic [3:0]  shown_nxt;
  logic [1:0]  scan_pos_r;
  logic [1:0]  scan_pos_nxt;
  logic [15:0] passes_left_r;
  logic [15:0] passes_left_nxt;
  logic [7:0]  last_seg_r;
  logic [7:0]  last_seg_nxt;
  logic [7:0]  sel_bit;
  logic [7:0]  sel;

  // result register
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [7:0]  out_segments_r;
  logic [7:0]  out_digit_select_r;
  logic [1:0]  out_position_r;

  assign advance = !out_valid_r || out_ready;
  assign fire    = dec_valid && advance;
  assign is_tick = (dec.cmd == CMD_TICK);

  // hundreds, tens and units of the remainder, blanking flags
  always_comb begin
    hund_prod     = 16'(dec.rem) * 16'(RECIP_100);
    hund          = hund_prod[15:12];
    rem100_full   = dec.rem - times_100(hund);
    rem100        = rem100_full[6:0];
    tens          = tens_digit(rem100);
    units_full    = rem100 - times_10(tens);
    load_codes[0] = units_full[3:0];
    load_codes[1] = tens;
    load_codes[2] = hund;
    load_codes[3] = dec.neg ? DASH_CODE : dec.thou;
    load_shown[3] = dec.neg || (dec.thou != 4'd0);
    load_shown[2] = (hund != 4'd0) || (!dec.neg && load_shown[3]);
    load_shown[1] = (tens != 4'd0) || load_shown[2];
    load_shown[0] = 1'b1;
  end

  // select byte for the current position
  always_comb begin
    sel_bit = 8'd1 << cfg.first_digit_pin;
    sel_bit = cfg.scan_upward ? (sel_bit << scan_pos_r) : (sel_bit >> scan_pos_r);
  end

  // next state of the store and scan
  always_comb begin
    codes_nxt       = codes_r;
    shown_nxt       = shown_r;
    scan_pos_nxt    = scan_pos_r;
    passes_left_nxt = passes_left_r;
    last_seg_nxt    = last_seg_r;
    sel             = 8'hFF;
    if (fire) begin
      if (!is_tick) begin
        codes_nxt       = load_codes;
        shown_nxt       = load_shown;
        scan_pos_nxt    = 2'd0;
        passes_left_nxt = dec.passes;
      end else if (passes_left_r != 16'd0) begin
        if (shown_r[scan_pos_r]) begin
          last_seg_nxt = seg_code(codes_r[scan_pos_r], cfg.common_anode);
          sel          = ~sel_bit;
        end
        scan_pos_nxt = scan_pos_r + 2'd1;
        if (scan_pos_r == 2'd3) begin
          passes_left_nxt = passes_left_r - 16'd1;
        end
      end
    end
  end

  // result valid follows ticks only
  always_comb begin
    if (advance) begin
      out_valid_nxt = dec_valid && is_tick;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        codes_r[i] <= 4'd0;
      end
      shown_r       <= 4'd0;
      scan_pos_r    <= 2'd0;
      passes_left_r <= 16'd0;
      last_seg_r    <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      codes_r       <= codes_nxt;
      shown_r       <= shown_nxt;
      scan_pos_r    <= scan_pos_nxt;
      passes_left_r <= passes_left_nxt;
      last_seg_r    <= last_seg_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire && is_tick) begin
      out_segments_r     <= last_seg_nxt;
      out_digit_select_r <= sel;
      out_position_r     <= scan_pos_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_segments     = out_segments_r;
  assign out_digit_select = out_digit_select_r;
  assign out_position     = out_position_r;

  // a load restarts the scan at the units position
  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_tick) |=> (scan_pos_r == 2'd0))
    else $error("scan position not cleared by load");

  // units position is always shown after a load
  a_units_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_tick) |=> shown_r[0])
    else $error("units position blanked after load");

  // no passes left: the scan holds and all digits are off
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_tick && (passes_left_r == 16'd0)) |=>
      ($stable(scan_pos_r) && (out_digit_select_r == 8'hFF)))
    else $error("scan moved or digit enabled with no passes left");

  // a blanked digit keeps the last segment byte
  a_blank_keeps_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_tick && !shown_r[scan_pos_r]) |=> $stable(last_seg_r))
    else $error("segment byte changed on a blanked digit");

endmodule

FILE: bench/tb_multiplexed_seven_segment_number_driver_top.sv
// ----------------------------------------------------------------------------
// tb_multiplexed_seven_segment_number_driver_top
// Self-checking bench for the four-digit multiplexed seven-segment driver.
// A queue-fed driver sends load and scan-tick beats with random gaps, a
// monitor predicts each scan result from its own display state and checks
// the result beats field by field; the register set is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_multiplexed_seven_segment_number_driver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mssd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;
  localparam int PRINT_CAP   = 50;

  // common-cathode segment patterns, index 10 is the minus sign
  localparam logic [7:0] CATHODE_SEG [0:15] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct {
    logic               cmd;
    logic signed [14:0] number;
    logic [15:0]        passes;
  } disp_cmd_t;

  typedef struct packed {
    logic [7:0] seg;
    logic [7:0] sel;
    logic [1:0] pos;
  } scan_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [2:0]         cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_cmd = CMD_LOAD;
  logic signed [14:0] in_number = '0;
  logic [15:0]        in_passes = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_segments;
  logic [7:0]         out_digit_select;
  logic [1:0]         out_position;

  multiplexed_seven_segment_number_driver_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_number        (in_number),
    .in_passes        (in_passes),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segments     (out_segments),
    .out_digit_select (out_digit_select),
    .out_position     (out_position)
  );

  // display state mirrored by the bench
  logic        anode_mode = 1'b0;
  logic [2:0]  pin0 = 3'd7;
  logic        upward = 1'b0;
  logic [3:0]  sym [0:3] = '{default: 4'd0};
  logic        lit [0:3] = '{default: 1'b0};
  logic [1:0]  scan_pos = 2'd0;
  logic [15:0] passes_left = 16'd0;
  logic [7:0]  last_seg = 8'd0;

  disp_cmd_t  cmd_backlog [$];
  scan_beat_t scan_due [$];
  disp_cmd_t  nxt_cmd;
  scan_beat_t want;
  scan_beat_t got;
  logic       in_fired = 1'b0;
  logic       calm = 1'b0;
  int         cycles = 0;
  int         mismatches = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // split a load into shown symbols and arm the pass count
  task automatic load_display(input logic signed [14:0] raw, input logic [15:0] cnt);
    int x;
    int mag;
    x = raw;
    if (x < -999) x = -999;
    if (x > 9999) x = 9999;
    if (x >= 0) begin
      mag = x;
      sym[3] = 4'(mag / 1000);
      mag = mag % 1000;
      lit[3] = (sym[3] != 4'd0);
    end else begin
      mag = -x;
      sym[3] = DASH_CODE;
      lit[3] = 1'b1;
    end
    sym[2] = 4'(mag / 100);
    mag = mag % 100;
    lit[2] = (sym[2] != 4'd0) || (x >= 0 && lit[3]);
    sym[1] = 4'(mag / 10);
    lit[1] = (sym[1] != 4'd0) || lit[2];
    sym[0] = 4'(mag % 10);
    lit[0] = 1'b1;
    passes_left = cnt;
    scan_pos = 2'd0;
  endtask

  // active-low select byte; a bit shifted out of the byte leaves all off
  function automatic logic [7:0] select_for(input logic [1:0] p);
    logic [15:0] b;
    b = 16'd1 << pin0;
    if (upward) b = b << p;
    else b = b >> p;
    return ~b[7:0];
  endfunction

  // one scan tick: drive current position, then step unless passes ran out
  task automatic scan_tick(output scan_beat_t r);
    logic [1:0] p;
    logic [7:0] sel;
    p = scan_pos;
    sel = 8'hFF;
    if (passes_left != 16'd0) begin
      if (lit[p]) begin
        last_seg = anode_mode ? ~CATHODE_SEG[sym[p]] : CATHODE_SEG[sym[p]];
        sel = select_for(p);
      end
      scan_pos = p + 2'd1;
      if (p == 2'd3) passes_left = passes_left - 16'd1;
    end
    r = '{seg: last_seg, sel: sel, pos: p};
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // input driver, one beat per handshake
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
        nxt_cmd = cmd_backlog.pop_front();
        in_cmd <= nxt_cmd.cmd;
        in_number <= nxt_cmd.number;
        in_passes <= nxt_cmd.passes;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 6);
  end

  // monitor: predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin
    in_fired <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      got = '{seg: out_segments, sel: out_digit_select, pos: out_position};
      if (scan_due.size() == 0) begin
        flag_mismatch($sformatf("result beat %h with nothing expected", got));
      end else begin
        want = scan_due.pop_front();
        if (got.seg !== want.seg)
          flag_mismatch($sformatf("segments %h, expected %h", got.seg, want.seg));
        if (got.sel !== want.sel)
          flag_mismatch($sformatf("digit_select %h, expected %h", got.sel, want.sel));
        if (got.pos !== want.pos)
          flag_mismatch($sformatf("position %0d, expected %0d", got.pos, want.pos));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      if (in_cmd == CMD_LOAD) begin
        load_display(in_number, in_passes);
      end else begin
        scan_tick(want);
        scan_due.push_back(want);
      end
    end
  end

  task automatic push_cmd(input logic c, input int num, input int cnt);
    disp_cmd_t d;
    d.cmd = c;
    d.number = 15'(num);
    d.passes = 16'(cnt);
    cmd_backlog.push_back(d);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_cmd(CMD_TICK, $urandom(), $urandom());
  endtask

  // number mix: in range, near zero, clamp edges and raw 15-bit values
  function automatic int pick_number();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 10998)) - 999;
      3:       v = int'($urandom_range(0, 40)) - 20;
      4: begin
        case ($urandom_range(0, 7))
          0: v = -999;
          1: v = -1000;
          2: v = 9999;
          3: v = 10000;
          4: v = 0;
          5: v = -1;
          6: v = -16384;
          default: v = 16383;
        endcase
      end
      5, 6:    v = int'($urandom_range(0, 32767));
      7:       v = int'($urandom_range(0, 99));
      default: v = -int'($urandom_range(1, 999));
    endcase
    return v;
  endfunction

  // mostly load-then-scan sequences, some stray beats
  task automatic queue_random(input int n);
    int added;
    int cnt;
    int k;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 99) < 8) begin
        push_cmd($urandom_range(0, 1), $urandom(), $urandom());
        added++;
      end else begin
        case ($urandom_range(0, 9))
          0:       cnt = 0;
          1:       cnt = $urandom_range(4, 20);
          2:       cnt = $urandom_range(0, 65535);
          default: cnt = $urandom_range(1, 3);
        endcase
        push_cmd(CMD_LOAD, pick_number(), cnt);
        k = $urandom_range(0, 4 * ((cnt > 3) ? 3 : cnt) + 6);
        push_ticks(k);
        added += k + 1;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_display_cfg(input logic an, input logic [2:0] pin, input logic up);
    write_reg(REG_COMMON_ANODE, {2'b00, an});
    write_reg(REG_FIRST_DIGIT_PIN, pin);
    write_reg(REG_SCAN_UPWARD, {2'b00, up});
    anode_mode = an;
    pin0 = pin;
    upward = up;
  endtask

  // wait until every beat is sent and every result has come back
  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid || scan_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: tick before any load, clamp edges, blanking, passes running out
    push_ticks(1);
    push_cmd(CMD_LOAD, 9999, 1);
    push_ticks(5);
    push_cmd(CMD_LOAD, -16384, 2);
    push_ticks(4);
    push_cmd(CMD_LOAD, 16383, 65535);
    push_ticks(2);
    push_cmd(CMD_LOAD, -7, 1);
    push_ticks(4);
    push_cmd(CMD_LOAD, 100, 1);
    push_ticks(3);
    push_cmd(CMD_LOAD, 0, 0);
    push_ticks(1);
    queue_random(200);
    drain();

    set_display_cfg(1'b1, 3'd0, 1'b1);
    queue_random(200);
    drain();

    // long stretch with no idling on either side
    calm = 1'b1;
    set_display_cfg(1'b0, 3'd3, 1'b0);
    queue_random(200);
    drain();
    calm = 1'b0;

    // select bit runs off the top, then off the bottom
    set_display_cfg(1'b1, 3'd7, 1'b1);
    queue_random(200);
    drain();
    set_display_cfg(1'b0, 3'd0, 1'b0);
    queue_random(200);
    drain();

    repeat (3) begin
      set_display_cfg($urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 1));
      queue_random(150);
      drain();
    end

    if (scan_due.size() != 0) flag_mismatch("expected results never arrived");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: multiplexed_seven_segment_number_driver_top.f
rtl/core/mssd_pkg.sv
rtl/core/mssd_split.sv
rtl/core/mssd_scan.sv
rtl/core/multiplexed_seven_segment_number_driver_top.sv
bench/tb_multiplexed_seven_segment_number_driver_top.sv
